[rtl/ppp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and tables for the planar point projector.
// No dependencies.
package ppp_pkg;
  localparam int CoordWidthDef   = 32;
  localparam int FracBitsDef     = 15;
  localparam int CordicStagesDef = 16;
  localparam int GuardBits       = 8;
  localparam int DataW           = 64;
  localparam int QDivW           = 48;
  localparam int RadiusW         = 31;
  localparam int CfgIdxW         = 2;
  localparam int CfgDataW        = 31;
  localparam int OutW            = 16;
  localparam int YawW            = 16;
  localparam logic [31:0] GainQ30 = 32'd652032874;
  localparam logic [CfgIdxW-1:0] RegRadius = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRotate = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFlip   = 2'd2;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic              vld;
    logic              rot;
    logic              flip;
    logic [RadiusW-1:0] radius;
  } ctl_t;
endpackage

[rtl/ppp_if.sv]
`timescale 1ns / 1ps
// Valid/ready word channel with a generic payload.
// No dependencies.
interface ppp_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/ppp_gain.sv]
`timescale 1ns / 1ps
// CORDIC gain removal on a signed 64-bit value, two register stages.
// Depends on ppp_pkg.
module ppp_gain (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [ppp_pkg::DataW-1:0] d,
  output logic signed [ppp_pkg::DataW-1:0] q
);
  import ppp_pkg::*;
  logic [DataW-1:0] m;
  logic             neg_r;
  logic [63:0]      ph_r, pl_r;
  logic [DataW-1:0] r;
  assign m = d[DataW-1] ? (-d) : d;
  assign r = (ph_r << 2) + ((pl_r + 64'd536870912) >> 30);
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= d[DataW-1];
      ph_r  <= m[63:32] * GainQ30;
      pl_r  <= m[31:0] * GainQ30;
      q     <= neg_r ? -r : r;
    end
  end
endmodule

[rtl/ppp_cell.sv]
`timescale 1ns / 1ps
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered.
// Depends on ppp_pkg.
module ppp_cell #(
  parameter int IDX = 0,
  parameter bit VEC = 1'b0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ppp_pkg::DataW-1:0] x_i,
  input  logic signed [ppp_pkg::DataW-1:0] y_i,
  input  logic [31:0]                      z_i,
  output logic signed [ppp_pkg::DataW-1:0] x_r,
  output logic signed [ppp_pkg::DataW-1:0] y_r,
  output logic [31:0]                      z_r
);
  import ppp_pkg::*;
  logic dir;
  logic [31:0] a;
  assign a   = atan_lut(5'(IDX));
  // vectoring drives y toward zero, rotation drives z toward zero
  assign dir = VEC ? y_i[DataW-1] : !z_i[31];
  always_ff @(posedge clk) begin
    if (en) begin
      if (dir) begin
        x_r <= x_i - (y_i >>> IDX);
        y_r <= y_i + (x_i >>> IDX);
        z_r <= z_i - a;
      end else begin
        x_r <= x_i + (y_i >>> IDX);
        y_r <= y_i - (x_i >>> IDX);
        z_r <= z_i + a;
      end
    end
  end
endmodule

[rtl/ppp_div.sv]
`timescale 1ns / 1ps
// Restoring divider cell: one quotient bit per stage, pipelined.
// No dependencies beyond ppp_pkg widths.
module ppp_div #(
  parameter int W = ppp_pkg::QDivW
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] rem_r,
  output logic [W-1:0] num_r,
  output logic [W-1:0] den_r
);
  logic [W:0] t;
  assign t = {rem_i, num_i[W-1]};
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      if (t >= {1'b0, den_i}) begin
        rem_r <= W'(t - {1'b0, den_i});
        num_r <= {num_i[W-2:0], 1'b1};
      end else begin
        rem_r <= t[W-1:0];
        num_r <= {num_i[W-2:0], 1'b0};
      end
    end
  end
endmodule

[rtl/planar_point_projector_unit.sv]
`timescale 1ns / 1ps
// Planar point projector: rotation CORDIC, vectoring CORDIC, divider chain.
// Accepts one word per cycle while the pipeline advances.
// Whole pipeline advances when the output register is free or taken.
// Synchronous active-low reset clears valids and the rotate and flip bits and sets radius to 1.
// Depends on ppp_pkg, ppp_if, ppp_cell, ppp_gain, ppp_div.
module planar_point_projector_unit #(
  parameter int COORD_WIDTH   = ppp_pkg::CoordWidthDef,
  parameter int FRAC_BITS     = ppp_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = ppp_pkg::CordicStagesDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_marker_x,
  input  logic signed [COORD_WIDTH-1:0] in_marker_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic [ppp_pkg::YawW-1:0]      in_view_yaw,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ppp_pkg::OutW-1:0] out_norm_right,
  output logic signed [ppp_pkg::OutW-1:0] out_norm_up,
  output logic                          out_within_range,
  output logic signed [ppp_pkg::OutW-1:0] out_bearing,
  input  logic                          cfg_we,
  input  logic [ppp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ppp_pkg::CfgDataW-1:0]  cfg_data
);
  import ppp_pkg::*;
  localparam int N = CORDIC_STAGES;
  localparam int LIM = 62 - FRAC_BITS;
  localparam int ND = LIM + 1;
  localparam int NQ = FRAC_BITS + 2;
  localparam int RW = 4*COORD_WIDTH + YawW;
  localparam int OW = 3*OutW + 1;

  ppp_if #(.W(RW)) in_ch ();
  ppp_if #(.W(OW)) out_ch ();
  assign in_ch.valid = in_valid;
  assign in_ch.data  = {in_marker_x, in_marker_y, in_origin_x, in_origin_y, in_view_yaw};
  assign in_ready    = in_ch.ready;
  assign out_valid   = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign {out_norm_right, out_norm_up, out_within_range, out_bearing} = out_ch.data;

  logic [RadiusW-1:0] radius_r;
  logic rot_r, flip_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RadiusW'(1); rot_r <= 1'b0; flip_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRadius: radius_r <= (cfg_data[RadiusW-1:0] == '0) ? RadiusW'(1)
                                                            : cfg_data[RadiusW-1:0];
        RegRotate: rot_r <= cfg_data[0];
        RegFlip:   flip_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic ovld_r;
  logic [OW-1:0] odat_r;
  logic en;
  assign en = !ovld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = ovld_r;
  assign out_ch.data = odat_r;

  // stage 0: difference and prerotate
  logic signed [DataW-1:0] da, db, px0, py0;
  logic [31:0] z0;
  logic [RW-1:0] dd;
  logic quad;
  assign dd = in_ch.data;
  always_comb begin
    da = (DataW'($signed(dd[RW-1 -: COORD_WIDTH]))
        - DataW'($signed(dd[RW-2*COORD_WIDTH-1 -: COORD_WIDTH]))) <<< GuardBits;
    db = (DataW'($signed(dd[RW-COORD_WIDTH-1 -: COORD_WIDTH]))
        - DataW'($signed(dd[RW-3*COORD_WIDTH-1 -: COORD_WIDTH]))) <<< GuardBits;
    z0 = {16'(-dd[YawW-1:0]), 16'd0};
    quad = (z0 >= 32'h4000_0000) && (z0 < 32'hC000_0000);
    if (quad) begin
      px0 = -da; py0 = -db; z0 = z0 + 32'h8000_0000;
    end else begin
      px0 = da; py0 = db;
    end
  end

  ctl_t ctl_s [0:N+2];
  logic signed [DataW-1:0] rx [0:N];
  logic signed [DataW-1:0] ry [0:N];
  logic [31:0] rz [0:N];
  logic signed [DataW-1:0] ux [0:N+2];
  logic signed [DataW-1:0] uy [0:N+2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N+2; k++) ctl_s[k].vld <= 1'b0;
    end else if (en) begin
      ctl_s[0].vld <= in_ch.valid;
      for (int k = 1; k <= N+2; k++) ctl_s[k].vld <= ctl_s[k-1].vld;
    end
    if (en) begin
      ctl_s[0].rot <= rot_r; ctl_s[0].flip <= flip_r; ctl_s[0].radius <= radius_r;
      rx[0] <= px0; ry[0] <= py0; rz[0] <= z0;
      ux[0] <= da; uy[0] <= db;
      for (int k = 1; k <= N+2; k++) begin
        ctl_s[k].rot <= ctl_s[k-1].rot; ctl_s[k].flip <= ctl_s[k-1].flip;
        ctl_s[k].radius <= ctl_s[k-1].radius;
        ux[k] <= ux[k-1]; uy[k] <= uy[k-1];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    ppp_cell #(.IDX(i), .VEC(1'b0)) u_c (
      .clk(clk), .en(en), .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]),
      .x_r(rx[i+1]), .y_r(ry[i+1]), .z_r(rz[i+1]));
  end

  logic signed [DataW-1:0] gx, gy;
  ppp_gain u_gx (.clk(clk), .en(en), .d(rx[N]), .q(gx));
  ppp_gain u_gy (.clk(clk), .en(en), .d(ry[N]), .q(gy));

  // up/right selection
  logic signed [DataW-1:0] upv, rtv;
  always_comb begin
    logic signed [DataW-1:0] fx, fy;
    fx = ctl_s[N+2].rot ? gx : ux[N+2];
    fy = ctl_s[N+2].rot ? gy : uy[N+2];
    upv = ctl_s[N+2].flip ? -fx : fx;
    rtv = fy;
  end

  // vectoring chain
  logic signed [DataW-1:0] vx [0:N];
  logic signed [DataW-1:0] vy [0:N];
  logic [31:0] vz [0:N];
  localparam int VD = N + 2;
  ctl_t vc [0:VD];
  logic signed [DataW-1:0] vup [0:VD];
  logic signed [DataW-1:0] vrt [0:VD];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= VD; k++) vc[k].vld <= 1'b0;
    end else if (en) begin
      vc[0].vld <= ctl_s[N+2].vld;
      for (int k = 1; k <= VD; k++) vc[k].vld <= vc[k-1].vld;
    end
    if (en) begin
      vc[0].rot <= 1'b0; vc[0].flip <= 1'b0; vc[0].radius <= ctl_s[N+2].radius;
      vup[0] <= upv; vrt[0] <= rtv;
      if (upv[DataW-1]) begin
        vx[0] <= -upv; vy[0] <= -rtv; vz[0] <= 32'h8000_0000;
      end else begin
        vx[0] <= upv; vy[0] <= rtv; vz[0] <= 32'd0;
      end
      for (int k = 1; k <= VD; k++) begin
        vc[k].rot <= 1'b0; vc[k].flip <= 1'b0; vc[k].radius <= vc[k-1].radius;
        vup[k] <= vup[k-1]; vrt[k] <= vrt[k-1];
      end
    end
  end
  for (genvar i = 0; i < N; i++) begin : g_vec
    ppp_cell #(.IDX(i), .VEC(1'b1)) u_v (
      .clk(clk), .en(en), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_r(vx[i+1]), .y_r(vy[i+1]), .z_r(vz[i+1]));
  end
  logic signed [DataW-1:0] mg;
  logic [31:0] vz1_r, vz2_r;
  ppp_gain u_gm (.clk(clk), .en(en), .d(vx[N]), .q(mg));
  always_ff @(posedge clk) begin
    if (en) begin vz1_r <= vz[N]; vz2_r <= vz1_r; end
  end

  // within, divisor, normalize
  logic [DataW-1:0] m_f, rad_s, den_a, cu_a, cr_a;
  logic within_a, zero_a;
  logic [OutW-1:0] bear_a;
  logic [31:0] zb;
  always_comb begin
    zero_a = (vup[VD] == '0) && (vrt[VD] == '0);
    m_f = zero_a ? '0 : (mg[DataW-1] ? -mg : mg);
    rad_s = DataW'(vc[VD].radius) << GuardBits;
    within_a = m_f <= rad_s;
    den_a = within_a ? rad_s : m_f;
    cu_a = vup[VD][DataW-1] ? -vup[VD] : vup[VD];
    cr_a = vrt[VD][DataW-1] ? -vrt[VD] : vrt[VD];
    zb = vz2_r + 32'h8000;
    bear_a = zero_a ? '0 : zb[31:16];
  end

  // shift-down count: leading-one position of the OR word
  logic [DataW-1:0] orv;
  logic [6:0] sh_a;
  assign orv = cu_a | cr_a | den_a;
  always_comb begin
    sh_a = '0;
    for (int k = LIM; k < DataW; k++) if (orv[k]) sh_a = 7'(k - LIM + 1);
  end
  logic [DataW-1:0] nu_r, nr_r, nd_r;
  logic [6:0] sh_r;
  logic un_r, rn_r, wi_r, nv_r;
  logic [OutW-1:0] be_r;
  always_ff @(posedge clk) begin
    if (!rst_n) nv_r <= 1'b0;
    else if (en) nv_r <= vc[VD].vld;
    if (en) begin
      nu_r <= cu_a; nr_r <= cr_a; nd_r <= den_a; sh_r <= sh_a;
      un_r <= vup[VD][DataW-1]; rn_r <= vrt[VD][DataW-1];
      wi_r <= within_a; be_r <= bear_a;
    end
  end
  logic [ND-1:0] su, sr, sd;
  always_comb begin
    logic [DataW-1:0] t;
    t = nd_r >> sh_r;
    sd = (t == '0) ? ND'(1) : t[ND-1:0];
    t = nu_r >> sh_r; su = t[ND-1:0];
    t = nr_r >> sh_r; sr = t[ND-1:0];
  end
  // numerator: (c<<F) + den/2, up to 63 bits
  logic [DataW-1:0] numu_r, numr_r;
  logic [ND-1:0] dd_r;
  logic un2_r, rn2_r, wi2_r, nv2_r;
  logic [OutW-1:0] be2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) nv2_r <= 1'b0;
    else if (en) nv2_r <= nv_r;
    if (en) begin
      numu_r <= (DataW'(su) << FRAC_BITS) + DataW'(sd >> 1);
      numr_r <= (DataW'(sr) << FRAC_BITS) + DataW'(sd >> 1);
      dd_r <= sd; un2_r <= un_r; rn2_r <= rn_r; wi2_r <= wi_r; be2_r <= be_r;
    end
  end
  // cap at den<<(F+1): quotient then fits NQ bits and still saturates
  logic [DataW-1:0] capv, cu_c, cr_c;
  assign capv = DataW'(dd_r) << (FRAC_BITS + 1);
  assign cu_c = (numu_r >= capv) ? capv : numu_r;
  assign cr_c = (numr_r >= capv) ? capv : numr_r;

  logic [ND-1:0] ur [0:NQ];
  logic [ND-1:0] un [0:NQ];
  logic [ND-1:0] ud [0:NQ];
  logic [ND-1:0] qr [0:NQ];
  logic [ND-1:0] qn [0:NQ];
  logic [ND-1:0] qd [0:NQ];
  logic dv [1:NQ];
  logic dun [1:NQ];
  logic drn [1:NQ];
  logic dwi [1:NQ];
  logic [OutW-1:0] dbe [1:NQ];
  assign ur[0] = ND'(cu_c >> NQ);
  assign un[0] = {cu_c[NQ-1:0], {(ND-NQ){1'b0}}};
  assign ud[0] = dd_r;
  assign qr[0] = ND'(cr_c >> NQ);
  assign qn[0] = {cr_c[NQ-1:0], {(ND-NQ){1'b0}}};
  assign qd[0] = dd_r;
  for (genvar i = 0; i < NQ; i++) begin : g_div
    ppp_div #(.W(ND)) u_du (
      .clk(clk), .en(en), .rem_i(ur[i]), .num_i(un[i]), .den_i(ud[i]),
      .rem_r(ur[i+1]), .num_r(un[i+1]), .den_r(ud[i+1]));
    ppp_div #(.W(ND)) u_dr (
      .clk(clk), .en(en), .rem_i(qr[i]), .num_i(qn[i]), .den_i(qd[i]),
      .rem_r(qr[i+1]), .num_r(qn[i+1]), .den_r(qd[i+1]));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NQ; k++) dv[k] <= 1'b0;
    end else if (en) begin
      dv[1] <= nv2_r;
      for (int k = 2; k <= NQ; k++) dv[k] <= dv[k-1];
    end
    if (en) begin
      dun[1] <= un2_r; drn[1] <= rn2_r; dwi[1] <= wi2_r; dbe[1] <= be2_r;
      for (int k = 2; k <= NQ; k++) begin
        dun[k] <= dun[k-1]; drn[k] <= drn[k-1]; dwi[k] <= dwi[k-1];
        dbe[k] <= dbe[k-1];
      end
    end
  end

  function automatic logic [OutW-1:0] to_q(input logic [NQ-1:0] q, input logic ng);
    logic [NQ-1:0] lim, c;
    begin
      lim = ng ? (NQ'(1) << FRAC_BITS) : ((NQ'(1) << FRAC_BITS) - NQ'(1));
      c = (q > lim) ? lim : q;
      c = ng ? -c : c;
      return c[OutW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (en) ovld_r <= dv[NQ];
    if (en) odat_r <= {to_q(qn[NQ][NQ-1:0], drn[NQ]), to_q(un[NQ][NQ-1:0], dun[NQ]),
                       dwi[NQ], dbe[NQ]};
  end
endmodule

[sim/tb_planar_point_projector_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for planar_point_projector_unit: random and directed words,
// bit-exact projection predictor, random stalls on both channels.
// Depends on ppp_pkg, ppp_if and the block's RTL.
module tb_planar_point_projector_unit;
  import ppp_pkg::*;

  localparam int CW = 32;
  localparam int FB = 15;
  localparam int STAGES = 16;
  localparam int LAT = 2 * STAGES + FB + 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CfgIdxW-1:0] RegNone = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] mx;
    logic signed [CW-1:0] my;
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic [YawW-1:0]      yaw;
  } marker_t;

  typedef struct packed {
    logic signed [OutW-1:0] right;
    logic signed [OutW-1:0] up;
    logic                   in_range;
    logic signed [OutW-1:0] bearing;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic go = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  ppp_if #(.W($bits(marker_t))) in_ch ();
  ppp_if #(.W($bits(proj_t))) out_ch ();

  marker_t pending_q[$];
  proj_t proj_q[$];
  logic [RadiusW-1:0] radius_m;
  logic rot_m, flip_m;
  logic sender_hold = 1'b0;
  logic rx_hold_req = 1'b0;
  int rx_hold_left = 0;
  int accepted = 0;
  int errors = 0;
  int cycles = 0;

  logic [31:0] angle_tab [0:STAGES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861};

  planar_point_projector_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_marker_x(in_ch.data[4*CW+YawW-1 -: CW]),
    .in_marker_y(in_ch.data[3*CW+YawW-1 -: CW]),
    .in_origin_x(in_ch.data[2*CW+YawW-1 -: CW]),
    .in_origin_y(in_ch.data[CW+YawW-1 -: CW]),
    .in_view_yaw(in_ch.data[YawW-1:0]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_norm_right(out_ch.data[3*OutW:2*OutW+1]),
    .out_norm_up(out_ch.data[2*OutW:OutW+1]),
    .out_within_range(out_ch.data[OutW]),
    .out_bearing(out_ch.data[OutW-1:0]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] asr64(logic [63:0] u, int s);
    return $unsigned($signed(u) >>> s);
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] u);
    return u[63] ? -u : u;
  endfunction

  function automatic logic [63:0] degain(logic [63:0] v);
    logic [63:0] hi, lo;
    hi = v >> 32;
    lo = {32'd0, v[31:0]};
    return ((hi * 64'd652032874) << 2) + ((lo * 64'd652032874 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic [63:0] degain_s(logic [63:0] u);
    logic [63:0] r;
    r = degain(abs64(u));
    return u[63] ? -r : r;
  endfunction

  function automatic logic [15:0] to_q15(logic [63:0] c, logic neg, logic [63:0] den);
    logic [63:0] q, lim;
    q = ((c << FB) + den / 2) / den;
    lim = neg ? (64'd1 << FB) : ((64'd1 << FB) - 1);
    if (q > lim) q = lim;
    return neg ? -q[15:0] : q[15:0];
  endfunction

  function automatic proj_t project(marker_t w);
    logic [63:0] px, py, nx, ny, up, right, x, y, m, den, cu, cr, rg;
    logic [31:0] z;
    logic [15:0] nyaw;
    logic in_rng;
    proj_t r;
    px = (64'($signed(w.mx)) - 64'($signed(w.ox))) << GuardBits;
    py = (64'($signed(w.my)) - 64'($signed(w.oy))) << GuardBits;
    if (rot_m) begin
      nyaw = -w.yaw;
      z = {nyaw, 16'd0};
      if (z >= 32'h4000_0000 && z < 32'hC000_0000) begin
        px = -px; py = -py; z = z + 32'h8000_0000;
      end
      for (int i = 0; i < STAGES; i++) begin
        if (!z[31]) begin
          nx = px - asr64(py, i); ny = py + asr64(px, i); z = z - angle_tab[i];
        end else begin
          nx = px + asr64(py, i); ny = py - asr64(px, i); z = z + angle_tab[i];
        end
        px = nx; py = ny;
      end
      px = degain_s(px);
      py = degain_s(py);
    end
    up = flip_m ? -px : px;
    right = py;
    x = up; y = right; z = '0;
    if (x[63]) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y[63]) begin
        nx = x - asr64(y, i); ny = y + asr64(x, i); z = z - angle_tab[i];
      end else begin
        nx = x + asr64(y, i); ny = y - asr64(x, i); z = z + angle_tab[i];
      end
      x = nx; y = ny;
    end
    m = degain(abs64(x));
    r.bearing = '0;
    if (up != 0 || right != 0) begin
      z = z + 32'h8000;
      r.bearing = z[31:16];
    end else begin
      m = 0;
    end
    rg = 64'(radius_m) << GuardBits;
    in_rng = m <= rg;
    den = in_rng ? rg : m;
    cu = abs64(up);
    cr = abs64(right);
    while (((cu | cr | den) >> (62 - FB)) != 0) begin
      cu = cu >> 1; cr = cr >> 1; den = den >> 1;
    end
    if (den == 0) den = 1;
    r.right = to_q15(cr, right[63], den);
    r.up = to_q15(cu, up[63], den);
    r.in_range = in_rng;
    return r;
  endfunction

  // driver
  initial in_ch.valid = 1'b0;
  initial in_ch.data = '0;
  always @(negedge clk) begin
    if (!go || sender_hold || pending_q.size() == 0 ||
        ((accepted < 600 || accepted > 900) && $urandom_range(99) < 6)) begin
      in_ch.valid <= 1'b0;
    end else begin
      in_ch.valid <= 1'b1;
      in_ch.data <= pending_q[0];
    end
  end

  // receiver, with a long hold-off on request
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (!go) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold_req && rx_hold_left == 0) begin
      rx_hold_left <= 3 * LAT;
      out_ch.ready <= 1'b0;
    end else if (rx_hold_left > 1) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_hold_left == 1) rx_hold_left <= -1;
      out_ch.ready <= !((accepted < 600 || accepted > 900) && $urandom_range(99) < 6);
    end
  end

  // monitor
  always @(posedge clk) begin
    proj_t exp_w, got;
    cycles <= cycles + 1;
    if (in_ch.valid && in_ch.ready) begin
      proj_q.push_back(project(pending_q[0]));
      void'(pending_q.pop_front());
      accepted <= accepted + 1;
    end
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (proj_q.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        errors = errors + 1;
      end else begin
        exp_w = proj_q.pop_front();
        if (got.right !== exp_w.right) begin
          $display("%0t norm_right: expected %0d actual %0d", $time, exp_w.right, got.right);
          errors = errors + 1;
        end
        if (got.up !== exp_w.up) begin
          $display("%0t norm_up: expected %0d actual %0d", $time, exp_w.up, got.up);
          errors = errors + 1;
        end
        if (got.in_range !== exp_w.in_range) begin
          $display("%0t within_range: expected %0d actual %0d", $time, exp_w.in_range,
                   got.in_range);
          errors = errors + 1;
        end
        if (got.bearing !== exp_w.bearing) begin
          $display("%0t bearing: expected %0d actual %0d", $time, exp_w.bearing,
                   got.bearing);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegRadius) radius_m = (val == '0) ? RadiusW'(1) : val;
    else if (idx == RegRotate) rot_m = val[0];
    else if (idx == RegFlip) flip_m = val[0];
  endtask

  task automatic configure(logic [CfgDataW-1:0] rad, logic rot, logic flip);
    write_reg(RegRadius, rad);
    write_reg(RegRotate, CfgDataW'(rot));
    write_reg(RegFlip, CfgDataW'(flip));
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && proj_q.size() == 0);
    @(negedge clk);
  endtask

  task automatic push(int mx, int my, int ox, int oy, int yaw);
    marker_t w;
    w.mx = mx; w.my = my; w.ox = ox; w.oy = oy; w.yaw = 16'(yaw);
    pending_q.push_back(w);
  endtask

  function automatic marker_t rand_word();
    marker_t w;
    int span;
    w.mx = $urandom; w.my = $urandom; w.ox = $urandom; w.oy = $urandom;
    w.yaw = 16'($urandom);
    case ($urandom_range(5))
      0, 1: begin
        span = 1 << $urandom_range(30);
        w.mx = w.ox + $signed($urandom_range(2 * span)) - span;
        w.my = w.oy + $signed($urandom_range(2 * span)) - span;
      end
      2: w.my = w.oy;
      3: w.mx = w.ox;
      4: begin
        w.mx = w.ox; w.my = w.oy;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CfgDataW-1:0] rand_radius();
    case ($urandom_range(3))
      0: return CfgDataW'($urandom_range(16));
      1: return CfgDataW'(1 << $urandom_range(30));
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  initial begin
    radius_m = RadiusW'(1); rot_m = 1'b0; flip_m = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    go <= 1'b1;

    // directed
    configure(0, 1'b1, 1'b0);
    push(0, 0, 0, 0, 0);
    push(5, 5, 5, 5, 12345);
    push(-100, 0, 0, 0, 0);
    push(-100, 0, 0, 0, 32768);
    push(2147483647, 2147483647, -2147483648, -2147483648, 65535);
    push(-2147483648, -2147483648, 2147483647, 2147483647, 0);
    push(2147483647, -2147483648, -2147483648, 2147483647, 16384);
    push(1, 0, 0, 0, 16384);
    push(1, 0, 0, 0, 49152);
    push(0, 1, 0, 0, 32768);
    push(0, -1, 0, 0, 8192);
    push(1, 1, 0, 0, 0);
    push(-1, -1, 0, 0, 24576);
    drain();
    configure(2147483647, 1'b0, 1'b1);
    push(100, 0, 0, 0, 0);
    push(-100, 0, 0, 0, 0);
    push(0, 0, 0, 0, 0);
    push(2147483647, 2147483647, -2147483648, -2147483648, 0);
    push(-2147483648, 0, 2147483647, 0, 0);
    push(0, 2147483647, 0, -2147483648, 0);
    drain();
    configure(1000, 1'b1, 1'b1);
    push(1000, 0, 0, 0, 0);
    push(0, -1000, 0, 0, 40000);
    push(707, 707, 0, 0, 1000);
    push(1001, 0, 0, 0, 65535);
    drain();
    write_reg(RegNone, 31'h7FFF_FFFF);

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      configure(rand_radius(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (ph == 3) rx_hold_req = 1'b1;
      for (int n = 0; n < 190; n++) begin
        pending_q.push_back(rand_word());
        if (ph == 3 && n == 20) begin
          wait (rx_hold_left != 0);
          rx_hold_req = 1'b0;
        end
        if (ph == 6 && n == 95) begin
          wait (pending_q.size() <= 1);
          sender_hold = 1'b1;
          wait (proj_q.size() == 0);
          @(negedge clk);
          sender_hold = 1'b0;
        end
      end
      drain();
    end

    repeat (LAT + 20) @(posedge clk);
    if (errors == 0 && proj_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
